/* hdl/bhpq_pkg.sv */
// Shared constants, codes and interface types for the binary heap priority queue.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

    // Heap capacity and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;
    localparam int DATA_W = 32;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Request modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // Heap ordering kinds.
    localparam logic KIND_MIN = 1'b0;
    localparam logic KIND_MAX = 1'b1;

    // Sequencer to storage: one write port and one read port.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    // Sequencer to the shared comparator: does a rank above b?
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_cmp_req;

endpackage

`default_nettype wire

/* hdl/binary_heap_priority_queue_top.sv */
// Insert writes the root directly on an empty heap and sifts up otherwise; pop
// skips the sift-down when it finds the heap empty or leaves it empty. The single
// RAM read port sets the pace: one level per cycle for sift-up, while sift-down takes
// each level in steps (left child read, right child read, child compare, swap compare).
// One request is in work at a time; the result register frees the input side.
// Synchronous active-low reset empties the heap and selects the min ordering.
// Top level: heap kind register, sequencer, comparator and heap RAM.
// Depends on bhpq_pkg, bhpq_ram, bhpq_rank and bhpq_seq.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_heap_kind,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_mode,
    input  wire logic [bhpq_pkg::DATA_W-1:0]     i_value,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic      [bhpq_pkg::DATA_W-1:0]     o_popped_value,
    output logic      [bhpq_pkg::DATA_W-1:0]     o_top_value,
    output logic      [bhpq_pkg::CNT_W-1:0]      o_entry_count,
    output logic      [1:0]                      o_status
);

    logic                          r_heap_kind;
    bhpq_pkg::t_cmp_req            w_cmp;
    bhpq_pkg::t_ram_req            w_ram;
    logic                          w_above;
    logic [bhpq_pkg::DATA_W-1:0]   w_rd_data;
    bhpq_pkg::t_status             w_status;

    // Ordering register; the write channel is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_kind <= bhpq_pkg::KIND_MIN;
        end else if (i_cfg_valid) begin
            r_heap_kind <= i_heap_kind;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Shared compare unit.
    bhpq_rank u_rank (
        .i_kind  (r_heap_kind),
        .i_cmp   (w_cmp),
        .o_above (w_above)
    );

    // Heap storage.
    bhpq_ram #(
        .WIDTH (bhpq_pkg::DATA_W),
        .DEPTH (bhpq_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr),
        .i_wr_data (w_ram.wr_data),
        .i_rd_addr (w_ram.rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sift sequencer and result register.
    bhpq_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_cmp          (w_cmp),
        .i_above        (w_above),
        .o_ram          (w_ram),
        .i_rd_data      (w_rd_data),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_status       (w_status)
    );

    assign o_status = w_status;

endmodule

`default_nettype wire

/* hdl/bhpq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/bhpq_rank.sv */
// Shared ordering comparator: tells whether one signed value sits above another.
// Depends on bhpq_pkg for the data width, request type and kind codes.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_rank (
    input  wire logic              i_kind,
    input  wire bhpq_pkg::t_cmp_req i_cmp,
    output logic                   o_above
);

    // A min heap puts the smaller value on top, a max heap the larger one.
    always_comb begin
        if (i_kind == bhpq_pkg::KIND_MAX) begin
            o_above = $signed(i_cmp.a) > $signed(i_cmp.b);
        end else begin
            o_above = $signed(i_cmp.a) < $signed(i_cmp.b);
        end
    end

endmodule

`default_nettype wire

/* hdl/bhpq_seq.sv */
// Sequencer for the heap: walks sift-up and sift-down one level at a time,
// driving the heap RAM and the shared comparator. Depends on bhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_mode,
    input  wire logic [bhpq_pkg::DATA_W-1:0]     i_value,
    output bhpq_pkg::t_cmp_req                   o_cmp,
    input  wire logic                            i_above,
    output bhpq_pkg::t_ram_req                   o_ram,
    input  wire logic [bhpq_pkg::DATA_W-1:0]     i_rd_data,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic      [bhpq_pkg::DATA_W-1:0]     o_popped_value,
    output logic      [bhpq_pkg::DATA_W-1:0]     o_top_value,
    output logic      [bhpq_pkg::CNT_W-1:0]      o_entry_count,
    output bhpq_pkg::t_status                    o_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_LAST,
        S_POP_LOAD,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CMP,
        S_DN_SWAP,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [bhpq_pkg::CNT_W-1:0]      r_count, n_count;
    logic [bhpq_pkg::ADDR_W-1:0]     r_pos, n_pos;
    logic [bhpq_pkg::ADDR_W-1:0]     r_pick, n_pick;
    logic [bhpq_pkg::DATA_W-1:0]     r_val, n_val;
    logic [bhpq_pkg::DATA_W-1:0]     r_left, n_left;
    logic [bhpq_pkg::DATA_W-1:0]     r_pick_val, n_pick_val;
    logic [bhpq_pkg::DATA_W-1:0]     r_top, n_top;
    logic [bhpq_pkg::DATA_W-1:0]     r_popped, n_popped;
    bhpq_pkg::t_status               r_status, n_status;
    logic                            r_res_valid, n_res_valid;
    logic [bhpq_pkg::DATA_W-1:0]     r_o_popped, n_o_popped;
    logic [bhpq_pkg::DATA_W-1:0]     r_o_top, n_o_top;
    logic [bhpq_pkg::CNT_W-1:0]      r_o_count, n_o_count;
    bhpq_pkg::t_status               r_o_status, n_o_status;

    logic [bhpq_pkg::IDX_W-1:0]      w_left, w_right, w_n;
    logic [bhpq_pkg::ADDR_W-1:0]     w_parent, w_gparent, w_ins_pos, w_ins_parent, w_last;
    logic                            w_full;
    bhpq_pkg::t_ram_req              w_ram;

    // Tree index arithmetic around the current hole position.
    always_comb begin
        w_left       = {1'b0, r_pos, 1'b1};
        w_right      = w_left + bhpq_pkg::IDX_W'(1);
        w_n          = bhpq_pkg::IDX_W'(r_count);
        w_parent     = (r_pos - bhpq_pkg::ADDR_W'(1)) >> 1;
        w_gparent    = (w_parent - bhpq_pkg::ADDR_W'(1)) >> 1;
        w_ins_pos    = r_count[bhpq_pkg::ADDR_W-1:0];
        w_ins_parent = (w_ins_pos - bhpq_pkg::ADDR_W'(1)) >> 1;
        w_last       = bhpq_pkg::ADDR_W'(r_count - bhpq_pkg::CNT_W'(1));
        w_full       = r_count >= bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH);
    end

    // Operand selection for the shared comparator.
    always_comb begin
        case (r_state)
            S_UP_CMP: begin
                o_cmp.a = r_val;
                o_cmp.b = i_rd_data;
            end
            S_DN_CMP: begin
                o_cmp.a = i_rd_data;
                o_cmp.b = r_left;
            end
            S_DN_SWAP: begin
                o_cmp.a = r_pick_val;
                o_cmp.b = r_val;
            end
            default: begin
                o_cmp.a = r_val;
                o_cmp.b = i_rd_data;
            end
        endcase
    end

    // Next-state logic. The moving value rides in r_val and is written into the hole
    // at r_pos only once it settles, which equals swapping per level.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_pick      = r_pick;
        n_val       = r_val;
        n_left      = r_left;
        n_pick_val  = r_pick_val;
        n_popped    = r_popped;
        n_status    = r_status;
        n_res_valid = r_res_valid & ~i_res_ready;
        n_o_popped  = r_o_popped;
        n_o_top     = r_o_top;
        n_o_count   = r_o_count;
        n_o_status  = r_o_status;
        w_ram.wr_en   = 1'b0;
        w_ram.wr_addr = r_pos;
        w_ram.wr_data = r_val;
        w_ram.rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_popped = '0;
                    n_status = bhpq_pkg::ST_OK;
                    if (i_mode == bhpq_pkg::MODE_INSERT) begin
                        if (w_full) begin
                            n_status = bhpq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_val   = i_value;
                            n_pos   = w_ins_pos;
                            n_count = r_count + bhpq_pkg::CNT_W'(1);
                            if (r_count == '0) begin
                                w_ram.wr_en   = 1'b1;
                                w_ram.wr_addr = '0;
                                w_ram.wr_data = i_value;
                                n_state       = S_DONE;
                            end else begin
                                w_ram.rd_addr = w_ins_parent;
                                n_state       = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bhpq_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_popped = r_top;
                            n_count  = r_count - bhpq_pkg::CNT_W'(1);
                            if (r_count == bhpq_pkg::CNT_W'(1)) begin
                                n_state = S_DONE;
                            end else begin
                                w_ram.rd_addr = w_last;
                                n_state       = S_POP_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP_CMP: begin
                w_ram.wr_en = 1'b1;
                if (i_above) begin
                    // Parent moves down into the hole.
                    w_ram.wr_data = i_rd_data;
                    n_pos         = w_parent;
                    if (w_parent == '0) begin
                        n_state = S_UP_LAST;
                    end else begin
                        w_ram.rd_addr = w_gparent;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_LAST: begin
                w_ram.wr_en = 1'b1;
                n_state     = S_DONE;
            end
            S_POP_LOAD: begin
                n_val   = i_rd_data;
                n_pos   = '0;
                n_state = S_DN_LEFT;
            end
            S_DN_LEFT: begin
                if (w_left < w_n) begin
                    w_ram.rd_addr = w_left[bhpq_pkg::ADDR_W-1:0];
                    n_state       = S_DN_RIGHT;
                end else begin
                    w_ram.wr_en = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DN_RIGHT: begin
                n_left = i_rd_data;
                if (w_right < w_n) begin
                    w_ram.rd_addr = w_right[bhpq_pkg::ADDR_W-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                // Pick the better child, or the left one when it stands alone.
                if ((w_right < w_n) && i_above) begin
                    n_pick_val = i_rd_data;
                    n_pick     = w_right[bhpq_pkg::ADDR_W-1:0];
                end else begin
                    n_pick_val = r_left;
                    n_pick     = w_left[bhpq_pkg::ADDR_W-1:0];
                end
                n_state = S_DN_SWAP;
            end
            S_DN_SWAP: begin
                w_ram.wr_en = 1'b1;
                if (i_above) begin
                    w_ram.wr_data = r_pick_val;
                    n_pos         = r_pick;
                    n_state       = S_DN_LEFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res_valid = 1'b1;
                    n_o_popped  = r_popped;
                    n_o_top     = (r_count != '0) ? r_top : '0;
                    n_o_count   = r_count;
                    n_o_status  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Keep a copy of the root so the top and popped value need no read.
        n_top = r_top;
        if (w_ram.wr_en && (w_ram.wr_addr == '0)) begin
            n_top = w_ram.wr_data;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_pos      <= n_pos;
        r_pick     <= n_pick;
        r_val      <= n_val;
        r_left     <= n_left;
        r_pick_val <= n_pick_val;
        r_top      <= n_top;
        r_popped   <= n_popped;
        r_status   <= n_status;
        r_o_popped <= n_o_popped;
        r_o_top    <= n_o_top;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
    end

    assign o_ram          = w_ram;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_res_valid    = r_res_valid;
    assign o_popped_value = r_o_popped;
    assign o_top_value    = r_o_top;
    assign o_entry_count  = r_o_count;
    assign o_status       = r_o_status;

endmodule

`default_nettype wire

/* hdl/bhpq_check.sv */
// Port-level checker for the heap queue, attached to the top level by bind.
// Depends on bhpq_pkg and binary_heap_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_check (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_res_valid,
    input wire logic                            i_res_ready,
    input wire logic [bhpq_pkg::DATA_W-1:0]     o_popped_value,
    input wire logic [bhpq_pkg::DATA_W-1:0]     o_top_value,
    input wire logic [bhpq_pkg::CNT_W-1:0]      o_entry_count,
    input wire logic [1:0]                      o_status
);

    // The count never exceeds the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_entry_count <= bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)))
        else $error("entry count above capacity");

    // A refused insert only happens on a full heap and removes nothing.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == bhpq_pkg::ST_FULL)) |->
        ((o_entry_count == bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)) && (o_popped_value == '0)))
        else $error("full status with wrong count or popped value");

    // A pop on an empty heap reports zeros throughout.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == bhpq_pkg::ST_EMPTY)) |->
        ((o_entry_count == '0) && (o_popped_value == '0) && (o_top_value == '0)))
        else $error("empty status with nonzero fields");

    // An empty heap shows a zero top.
    a_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_entry_count == '0)) |-> (o_top_value == '0))
        else $error("nonzero top on empty heap");

    // A stalled result stays valid and holds its top value and count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
        (o_res_valid && $stable(o_top_value) && $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind binary_heap_priority_queue_top bhpq_check u_bhpq_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_popped_value (o_popped_value),
    .o_top_value    (o_top_value),
    .o_entry_count  (o_entry_count),
    .o_status       (o_status)
);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for binary_heap_priority_queue_top: a scoreboard class mirrors the
// heap and checks every result against its own prediction of the block.
// Depends on bhpq_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int END_PAUSE  = 40;

    // One predicted result of the block.
    typedef struct {
        logic [bhpq_pkg::DATA_W-1:0] popped;
        logic [bhpq_pkg::DATA_W-1:0] top;
        logic [bhpq_pkg::CNT_W-1:0]  count;
        bhpq_pkg::t_status           status;
    } t_heap_result;

    // Mirror of the heap that predicts each result and checks the block's output.
    class heap_scoreboard;
        logic [bhpq_pkg::DATA_W-1:0] slots[bhpq_pkg::DEPTH];
        int                          stored;
        logic                        kind;
        t_heap_result                awaited[$];
        int                          errors;

        function new();
            stored = 0;
            kind   = bhpq_pkg::KIND_MIN;
            errors = 0;
        endfunction

        function void set_kind(logic k);
            kind = k;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // True when a must sit above b under the current ordering.
        function bit outranks(logic [bhpq_pkg::DATA_W-1:0] a,
                              logic [bhpq_pkg::DATA_W-1:0] b);
            if (kind == bhpq_pkg::KIND_MAX)
                return $signed(a) > $signed(b);
            return $signed(a) < $signed(b);
        endfunction

        function void swap_slots(int i, int j);
            logic [bhpq_pkg::DATA_W-1:0] t;
            t        = slots[i];
            slots[i] = slots[j];
            slots[j] = t;
        endfunction

        function void bubble_up(int pos);
            int parent;
            while (pos > 0) begin
                parent = (pos - 1) >> 1;
                if (!outranks(slots[pos], slots[parent]))
                    break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        // Push the root down, taking the better child (or the only one) per level.
        function void bubble_down(int n);
            int pos;
            int left;
            int right;
            int pick;
            pos = 0;
            while (1) begin
                left  = 2 * pos + 1;
                right = left + 1;
                if (left >= n)
                    break;
                pick = left;
                if (right < n && outranks(slots[right], slots[left]))
                    pick = right;
                if (!outranks(slots[pick], slots[pos]))
                    break;
                swap_slots(pos, pick);
                pos = pick;
            end
        endfunction

        // An accepted request: update the mirror and queue the result it must cause.
        function void note_request(logic mode, logic [bhpq_pkg::DATA_W-1:0] value);
            t_heap_result r;
            r.popped = '0;
            r.status = bhpq_pkg::ST_OK;
            if (mode == bhpq_pkg::MODE_INSERT) begin
                if (stored >= bhpq_pkg::DEPTH) begin
                    r.status = bhpq_pkg::ST_FULL;
                end else begin
                    slots[stored] = value;
                    stored++;
                    bubble_up(stored - 1);
                end
            end else begin
                if (stored == 0) begin
                    r.status = bhpq_pkg::ST_EMPTY;
                end else begin
                    r.popped = slots[0];
                    stored--;
                    if (stored > 0) begin
                        slots[0] = slots[stored];
                        bubble_down(stored);
                    end
                end
            end
            r.top   = (stored > 0) ? slots[0] : '0;
            r.count = stored[bhpq_pkg::CNT_W-1:0];
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // An accepted result: compare it field by field with the oldest prediction.
        task check_result(logic [bhpq_pkg::DATA_W-1:0] popped,
                          logic [bhpq_pkg::DATA_W-1:0] top,
                          logic [bhpq_pkg::CNT_W-1:0] count, logic [1:0] status);
            t_heap_result r;
            if (awaited.size() == 0) begin
                report("result arrived with none outstanding");
            end else begin
                r = awaited.pop_front();
                if (popped !== r.popped)
                    report($sformatf("popped_value %h, predicted %h", popped, r.popped));
                if (top !== r.top)
                    report($sformatf("top_value %h, predicted %h", top, r.top));
                if (count !== r.count)
                    report($sformatf("entry_count %0d, predicted %0d", count, r.count));
                if (status !== r.status)
                    report($sformatf("status %0d, predicted %0d", status, r.status));
            end
        endtask
    endclass

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_valid    = 1'b0;
    logic                           i_heap_kind    = bhpq_pkg::KIND_MIN;
    logic                           i_in_valid     = 1'b0;
    logic                           i_mode         = bhpq_pkg::MODE_INSERT;
    logic [bhpq_pkg::DATA_W-1:0]    i_value        = '0;
    logic                           i_res_ready    = 1'b0;
    logic                           o_cfg_ready;
    logic                           o_in_ready;
    logic                           o_res_valid;
    logic [bhpq_pkg::DATA_W-1:0]    o_popped_value;
    logic [bhpq_pkg::DATA_W-1:0]    o_top_value;
    logic [bhpq_pkg::CNT_W-1:0]     o_entry_count;
    logic [1:0]                     o_status;

    heap_scoreboard     sb = new();
    bit                 quiet = 1'b0;
    int                 stall_left = 0;
    int                 idle_cycles = 0;

    binary_heap_priority_queue_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_heap_kind    (i_heap_kind),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: random stall bursts, none in the quiet stretch.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_res_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 7) - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_result(o_popped_value, o_top_value, o_entry_count, o_status);
    end

    // Watchdog on cycles in which no request or result moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_res_valid && i_res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly random words, with small values for ties and the signed extremes.
    function automatic logic [bhpq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2, 3: return bhpq_pkg::DATA_W'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    // Offer one request and hold it until it is taken. Valid stays high into the
    // next request unless a random gap is taken first.
    task automatic send_request(logic mode, logic [bhpq_pkg::DATA_W-1:0] value);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(mode, value);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Drain outstanding work, then write the heap kind.
    task automatic write_kind(logic k);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_heap_kind <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_kind(k);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_mixed(int n, int insert_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < insert_pct)
                send_request(bhpq_pkg::MODE_INSERT, pick_value());
            else
                send_request(bhpq_pkg::MODE_POP, $urandom());
        end
    endtask

    // Fill past capacity, optionally pause until drained, then empty past zero.
    task automatic fill_and_drain(bit hold);
        repeat (bhpq_pkg::DEPTH - sb.stored + $urandom_range(1, 4))
            send_request(bhpq_pkg::MODE_INSERT, pick_value());
        if (hold) begin
            i_in_valid <= 1'b0;
            wait_drained();
        end
        repeat (sb.stored + $urandom_range(1, 3))
            send_request(bhpq_pkg::MODE_POP, $urandom());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop on empty, signed extremes, ties, then drain past empty.
        send_request(bhpq_pkg::MODE_POP, 32'h0);
        send_request(bhpq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_request(bhpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(bhpq_pkg::MODE_INSERT, 32'h0000_0000);
        send_request(bhpq_pkg::MODE_INSERT, 32'hffff_ffff);
        send_request(bhpq_pkg::MODE_INSERT, 32'h0000_0001);
        send_request(bhpq_pkg::MODE_INSERT, 32'h0000_0005);
        send_request(bhpq_pkg::MODE_INSERT, 32'h0000_0005);
        repeat (3) send_request(bhpq_pkg::MODE_POP, 32'hffff_ffff);
        send_request(bhpq_pkg::MODE_INSERT, 32'hffff_ffff);
        repeat (6) send_request(bhpq_pkg::MODE_POP, 32'h0);
        write_kind(bhpq_pkg::KIND_MAX);
        send_request(bhpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(bhpq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_request(bhpq_pkg::MODE_INSERT, 32'h0000_0000);
        repeat (3) send_request(bhpq_pkg::MODE_POP, 32'h0);

        // Random mix under the max ordering.
        run_mixed(120, 60);

        // Fill to full and drain, once per ordering; the second pauses when full.
        write_kind(bhpq_pkg::KIND_MIN);
        fill_and_drain(1'b0);
        write_kind(bhpq_pkg::KIND_MAX);
        fill_and_drain(1'b1);

        // Random ordering, lightly insert-heavy.
        write_kind(1'($urandom_range(0, 1)));
        run_mixed(150, 55);

        // Ordering switched while entries are stored.
        write_kind(bhpq_pkg::KIND_MIN);
        run_mixed(20, 100);
        write_kind(bhpq_pkg::KIND_MAX);
        run_mixed(60, 50);
        repeat (sb.stored + 1) send_request(bhpq_pkg::MODE_POP, $urandom());

        // Last stretch runs without any idling.
        write_kind(1'($urandom_range(0, 1)));
        quiet = 1'b1;
        run_mixed(120, 55);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (END_PAUSE) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
